[src/circle_outline_raster_macros.svh]
// Assertion macros for the circle outline rasterizer.
// Included by the top level; depends on nothing else.
`ifndef CIRCLE_OUTLINE_RASTER_MACROS_SVH
`define CIRCLE_OUTLINE_RASTER_MACROS_SVH
`ifndef ASSERT_OFF
`define COR_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define COR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define COR_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define COR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

[src/cor_pkg.sv]
// Package for the circle outline rasterizer: field widths, constants and types.
// Used by circle_outline_raster; depends on nothing else.
package cor_pkg;

   localparam int CENTER_W   = 12;
   localparam int RADIUS_W   = 6;
   localparam int COLOR_W    = 32;
   localparam int DIM_W      = 13;
   localparam int ADDR_W     = 24;
   localparam int POINTS     = 8;
   localparam int POINT_W    = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam int MAX_RADIUS_DEFAULT = 32;
   localparam int MAX_STEPS          = 40;
   localparam int STEP_W             = $clog2(MAX_STEPS + 1);

   localparam logic [DIM_W-1:0] IMAGE_WIDTH_RESET  = 13'd1024;
   localparam logic [DIM_W-1:0] IMAGE_HEIGHT_RESET = 13'd1024;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_POINT,
      ST_PRESENT
   } state_type;

   typedef enum logic [0:0] {
      REG_IMAGE_WIDTH,
      REG_IMAGE_HEIGHT
   } reg_index_type;

endpackage

[src/circle_outline_raster.sv]
// Circle outline rasterizer top level: octant walk, shared address unit, register port.
// Depends on cor_pkg and circle_outline_raster_macros.svh.
//
// Each accepted request walks one octant of the circle from (0, r) while y >= x, for at
// most MAX_STEPS steps, and gives one transfer per step with the eight mirrored pixel
// addresses, the color, an inside-image mask and a last flag. A single multiply-add
// unit forms one address per cycle, so a step forms its eight addresses in turn in
// ST_POINT and then presents the result in ST_PRESENT until it is transferred.
// A radius r gives about 0.71*r + 1 results; a radius of 32 gives 24 results. The
// request side is stalled from acceptance until the last result is transferred.
`include "circle_outline_raster_macros.svh"

module circle_outline_raster #(
   parameter int MAX_RADIUS = cor_pkg::MAX_RADIUS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [cor_pkg::CENTER_W-1:0]   req_center_x,
   input  logic [cor_pkg::CENTER_W-1:0]   req_center_y,
   input  logic [cor_pkg::RADIUS_W-1:0]   req_radius,
   input  logic [cor_pkg::COLOR_W-1:0]    req_color,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [cor_pkg::ADDR_W-1:0]     rsp_pixel_addr_0,
   output logic [cor_pkg::ADDR_W-1:0]     rsp_pixel_addr_1,
   output logic [cor_pkg::ADDR_W-1:0]     rsp_pixel_addr_2,
   output logic [cor_pkg::ADDR_W-1:0]     rsp_pixel_addr_3,
   output logic [cor_pkg::ADDR_W-1:0]     rsp_pixel_addr_4,
   output logic [cor_pkg::ADDR_W-1:0]     rsp_pixel_addr_5,
   output logic [cor_pkg::ADDR_W-1:0]     rsp_pixel_addr_6,
   output logic [cor_pkg::ADDR_W-1:0]     rsp_pixel_addr_7,
   output logic [cor_pkg::COLOR_W-1:0]    rsp_pixel_color,
   output logic [cor_pkg::POINTS-1:0]     rsp_inside_mask,
   output logic                           rsp_last_step,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [cor_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [cor_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [cor_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);

   localparam int OFFSET_W = $clog2(MAX_RADIUS + 2);
   localparam int D_W      = OFFSET_W + 3;
   localparam int COORD_W  = ((cor_pkg::CENTER_W > OFFSET_W) ? cor_pkg::CENTER_W
                                                              : OFFSET_W) + 2;
   localparam int PROD_W   = COORD_W + cor_pkg::DIM_W + 1;
   localparam logic signed [D_W-1:0] D_ONE = D_W'(1);
   localparam logic signed [D_W-1:0] D_TWO = D_W'(2);

   cor_pkg::state_type state_ff, state_in;

   logic [cor_pkg::DIM_W-1:0]    width_ff, height_ff;
   logic [cor_pkg::CENTER_W-1:0] cx_ff, cy_ff;
   logic [cor_pkg::COLOR_W-1:0]  color_ff;
   logic [OFFSET_W-1:0]          r_ff, x_ff, y_ff;
   logic signed [D_W-1:0]        d_ff;
   logic [cor_pkg::POINT_W-1:0]  idx_ff;
   logic [cor_pkg::STEP_W-1:0]   step_cnt_ff;
   logic [cor_pkg::ADDR_W-1:0]   addr_ff [cor_pkg::POINTS];
   logic [cor_pkg::POINTS-1:0]   mask_ff;
   logic                         last_ff;

   logic                         req_xfer, rsp_xfer, csr_write;
   logic [OFFSET_W-1:0]          r_sat;
   logic signed [D_W-1:0]        d_init;

   logic [OFFSET_W-1:0]          col_off, row_off;
   logic signed [COORD_W-1:0]    cx_ext, cy_ext, col_off_ext, row_off_ext;
   logic signed [COORD_W-1:0]    col, row;
   logic signed [PROD_W-1:0]     row_base;
   logic [cor_pkg::ADDR_W-1:0]   addr_calc;
   logic                         inside_calc;

   logic signed [D_W-1:0]        two_x, two_y, two_ry, d_in;
   logic [OFFSET_W:0]            x_inc, y_dec, x_in, y_in;
   logic                         step_more;

   assign req_xfer  = req_valid && !req_stall;
   assign rsp_xfer  = rsp_valid && !rsp_stall;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_comb begin
      unique case (cor_pkg::reg_index_type'(csr_paddr[2]))
         cor_pkg::REG_IMAGE_WIDTH:  csr_prdata = (cor_pkg::CSR_DATA_W)'(width_ff);
         cor_pkg::REG_IMAGE_HEIGHT: csr_prdata = (cor_pkg::CSR_DATA_W)'(height_ff);
         default:                   csr_prdata = '0;
      endcase
   end

   assign r_sat  = OFFSET_W'((32'(req_radius) > MAX_RADIUS) ? MAX_RADIUS
                                                             : 32'(req_radius));
   assign d_init = $signed({{(D_W-OFFSET_W){1'b0}}, r_sat}) - D_ONE;

   // Shared address unit: bit 0 of the point index swaps x and y, bit 1 negates the
   // column offset and bit 2 negates the row offset.
   always_comb begin
      col_off     = idx_ff[0] ? y_ff : x_ff;
      row_off     = idx_ff[0] ? x_ff : y_ff;
      cx_ext      = $signed({{(COORD_W-cor_pkg::CENTER_W){1'b0}}, cx_ff});
      cy_ext      = $signed({{(COORD_W-cor_pkg::CENTER_W){1'b0}}, cy_ff});
      col_off_ext = $signed({{(COORD_W-OFFSET_W){1'b0}}, col_off});
      row_off_ext = $signed({{(COORD_W-OFFSET_W){1'b0}}, row_off});
      col         = idx_ff[1] ? (cx_ext - col_off_ext) : (cx_ext + col_off_ext);
      row         = idx_ff[2] ? (cy_ext - row_off_ext) : (cy_ext + row_off_ext);
      row_base    = row * $signed({1'b0, width_ff});
      addr_calc   = row_base[cor_pkg::ADDR_W-1:0]
                  + {{(cor_pkg::ADDR_W-COORD_W){col[COORD_W-1]}}, col};
      inside_calc = !col[COORD_W-1] && (col < $signed({1'b0, width_ff}))
                 && !row[COORD_W-1] && (row < $signed({1'b0, height_ff}));
   end

   always_comb begin
      two_x  = $signed({{(D_W-OFFSET_W-1){1'b0}}, x_ff, 1'b0});
      two_y  = $signed({{(D_W-OFFSET_W-1){1'b0}}, y_ff, 1'b0});
      two_ry = $signed({{(D_W-OFFSET_W-1){1'b0}}, OFFSET_W'(r_ff - y_ff), 1'b0});
      x_inc  = {1'b0, x_ff} + (OFFSET_W+1)'(1);
      y_dec  = {1'b0, y_ff} - (OFFSET_W+1)'(1);
      priority if (d_ff >= two_x) begin
         d_in = d_ff - two_x - D_ONE;
         x_in = x_inc;
         y_in = {1'b0, y_ff};
      end else if (d_ff < two_ry) begin
         d_in = d_ff + two_y - D_ONE;
         x_in = {1'b0, x_ff};
         y_in = y_dec;
      end else begin
         d_in = d_ff + two_y - two_x - D_TWO;
         x_in = x_inc;
         y_in = y_dec;
      end
      step_more = ($signed(y_in) >= $signed(x_in))
               && (32'(step_cnt_ff) < cor_pkg::MAX_STEPS - 1);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cor_pkg::ST_IDLE: begin
            if (req_xfer) state_in = cor_pkg::ST_POINT;
         end
         cor_pkg::ST_POINT: begin
            if (idx_ff == cor_pkg::POINT_W'(cor_pkg::POINTS - 1)) begin
               state_in = cor_pkg::ST_PRESENT;
            end
         end
         cor_pkg::ST_PRESENT: begin
            if (rsp_xfer) state_in = last_ff ? cor_pkg::ST_IDLE : cor_pkg::ST_POINT;
         end
         default: state_in = cor_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      unique case (state_ff)
         cor_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            rsp_valid = 1'b0;
         end
         cor_pkg::ST_POINT: begin
            req_stall = 1'b1;
            rsp_valid = 1'b0;
         end
         cor_pkg::ST_PRESENT: begin
            req_stall = 1'b1;
            rsp_valid = 1'b1;
         end
         default: begin
            req_stall = 1'b1;
            rsp_valid = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= cor_pkg::ST_IDLE;
         width_ff    <= cor_pkg::IMAGE_WIDTH_RESET;
         height_ff   <= cor_pkg::IMAGE_HEIGHT_RESET;
         idx_ff      <= '0;
         step_cnt_ff <= '0;
         x_ff        <= '0;
         y_ff        <= '0;
         d_ff        <= '0;
         r_ff        <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_write) begin
            unique case (cor_pkg::reg_index_type'(csr_paddr[2]))
               cor_pkg::REG_IMAGE_WIDTH:  width_ff  <= csr_pwdata[cor_pkg::DIM_W-1:0];
               cor_pkg::REG_IMAGE_HEIGHT: height_ff <= csr_pwdata[cor_pkg::DIM_W-1:0];
               default: ;
            endcase
         end
         if (req_xfer) begin
            r_ff        <= r_sat;
            x_ff        <= '0;
            y_ff        <= r_sat;
            d_ff        <= d_init;
            idx_ff      <= '0;
            step_cnt_ff <= '0;
         end else if (state_ff == cor_pkg::ST_POINT) begin
            idx_ff <= idx_ff + cor_pkg::POINT_W'(1);
            if (idx_ff == cor_pkg::POINT_W'(cor_pkg::POINTS - 1)) begin
               x_ff        <= x_in[OFFSET_W-1:0];
               y_ff        <= y_in[OFFSET_W-1:0];
               d_ff        <= d_in;
               step_cnt_ff <= step_cnt_ff + cor_pkg::STEP_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         cx_ff    <= req_center_x;
         cy_ff    <= req_center_y;
         color_ff <= req_color;
      end
      if (state_ff == cor_pkg::ST_POINT) begin
         addr_ff[idx_ff] <= addr_calc;
         mask_ff[idx_ff] <= inside_calc;
         if (idx_ff == cor_pkg::POINT_W'(cor_pkg::POINTS - 1)) begin
            last_ff <= !step_more;
         end
      end
   end

   assign rsp_pixel_addr_0 = addr_ff[0];
   assign rsp_pixel_addr_1 = addr_ff[1];
   assign rsp_pixel_addr_2 = addr_ff[2];
   assign rsp_pixel_addr_3 = addr_ff[3];
   assign rsp_pixel_addr_4 = addr_ff[4];
   assign rsp_pixel_addr_5 = addr_ff[5];
   assign rsp_pixel_addr_6 = addr_ff[6];
   assign rsp_pixel_addr_7 = addr_ff[7];
   assign rsp_pixel_color  = color_ff;
   assign rsp_inside_mask  = mask_ff;
   assign rsp_last_step    = last_ff;

   `COR_ASSERT_IMPL(a_valid_only_busy, clock, reset, !req_stall, !rsp_valid, "result while idle")
   `COR_ASSERT_NEXT(a_busy_after_req, clock, reset, req_xfer, req_stall, "not busy after request")
   `COR_ASSERT_NEXT(a_idle_after_last, clock, reset, rsp_xfer && rsp_last_step, !req_stall && !rsp_valid, "not idle after last transfer")
   `COR_ASSERT_IMPL(a_step_count, clock, reset, rsp_valid, (step_cnt_ff != '0) && (32'(step_cnt_ff) <= cor_pkg::MAX_STEPS), "step count out of range")

endmodule
